// File: rtl/odc_pkg.sv
package odc_pkg;

  localparam int VALUE_W = 12;
  localparam int ANGLE_W = 15;
  localparam int RND_W   = 6;
  localparam int SPEED_W = 16;
  localparam int CSPD_W  = 15;
  localparam int CANG_W  = 14;
  localparam int TIMER_W = 8;
  localparam int SUM_W   = 24;
  localparam int CX_W    = 48;
  localparam int CZ_W    = 32;
  localparam int GAIN_W  = 24;
  localparam int NUM_W   = CSPD_W + CANG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [CZ_W-1:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [CZ_W-1:0] PI_Q24      = 32'sd52707179;
  localparam logic [GAIN_W-1:0]      INV_GAIN_Q24 = 24'd10188014;

  typedef enum logic [1:0] {
    MOT_WALK  = 2'd0,
    MOT_SPIN  = 2'd1,
    MOT_AVOID = 2'd2
  } motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_STILL_LEN = 3'd1,
    CFG_WALK_LIM  = 3'd2,
    CFG_WALK_SPD  = 3'd3,
    CFG_SPIN_SPD  = 3'd4,
    CFG_MAX_SPD   = 3'd5,
    CFG_NO_TURN   = 3'd6,
    CFG_SOFT_TURN = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT_GO,
    S_ROT_WAIT,
    S_ACC,
    S_LEN_X,
    S_LEN_Y,
    S_LEN_L,
    S_CMP,
    S_HEAD_GO,
    S_HEAD_WAIT,
    S_STEER,
    S_SEL,
    S_DIV_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_cmd_t;

  function automatic logic signed [CZ_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [CZ_W-1:0] r;
    case (idx)
      5'd0:  r = 32'sd13176795;
      5'd1:  r = 32'sd7778716;
      5'd2:  r = 32'sd4110060;
      5'd3:  r = 32'sd2086331;
      5'd4:  r = 32'sd1047214;
      5'd5:  r = 32'sd524117;
      5'd6:  r = 32'sd262123;
      5'd7:  r = 32'sd131069;
      5'd8:  r = 32'sd65536;
      5'd9:  r = 32'sd32768;
      5'd10: r = 32'sd16384;
      5'd11: r = 32'sd8192;
      5'd12: r = 32'sd4096;
      5'd13: r = 32'sd2048;
      5'd14: r = 32'sd1024;
      5'd15: r = 32'sd512;
      5'd16: r = 32'sd256;
      5'd17: r = 32'sd128;
      5'd18: r = 32'sd64;
      5'd19: r = 32'sd32;
      5'd20: r = 32'sd16;
      5'd21: r = 32'sd8;
      5'd22: r = 32'sd4;
      5'd23: r = 32'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/odc_if.sv
interface odc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [odc_pkg::VALUE_W-1:0]            reading_value;
  logic signed [odc_pkg::ANGLE_W-1:0]     reading_angle;
  logic                                   last_reading;
  logic [odc_pkg::RND_W-1:0]              turn_random;
  modport source (output valid, reading_value, reading_angle, last_reading, turn_random,
                  input ready);
  modport sink (input valid, reading_value, reading_angle, last_reading, turn_random,
                output ready);
endinterface

interface odc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [odc_pkg::SPEED_W-1:0]     left_speed;
  logic signed [odc_pkg::SPEED_W-1:0]     right_speed;
  logic [1:0]                             motion_state;
  logic [odc_pkg::TIMER_W-1:0]            tick_count;
  modport source (output valid, left_speed, right_speed, motion_state, tick_count,
                  input ready);
  modport sink (input valid, left_speed, right_speed, motion_state, tick_count,
                output ready);
endinterface

interface odc_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [odc_pkg::CFG_IDX_W-1:0]          index;
  logic [odc_pkg::CFG_DATA_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/odc_cordic.sv
module odc_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  odc_pkg::cordic_cmd_t                 cmd,
  input  logic signed [odc_pkg::CX_W-1:0]      x0,
  input  logic signed [odc_pkg::CX_W-1:0]      y0,
  input  logic signed [odc_pkg::CZ_W-1:0]      z0,
  output logic                                 done,
  output logic signed [odc_pkg::CX_W-1:0]      x,
  output logic signed [odc_pkg::CX_W-1:0]      y,
  output logic signed [odc_pkg::CZ_W-1:0]      z
);
  localparam int CNT_W = $clog2(STEPS);

  logic                             busy_r, done_r, vec_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic signed [odc_pkg::CX_W-1:0]  x_r, y_r, xs, ys;
  logic signed [odc_pkg::CZ_W-1:0]  z_r, at;
  logic                             pos;

  always_comb begin
    xs  = x_r >>> cnt_r;
    ys  = y_r >>> cnt_r;
    at  = odc_pkg::atan_q24(5'(cnt_r));
    pos = vec_r ? y_r[odc_pkg::CX_W-1] : ~z_r[odc_pkg::CZ_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= cmd.vectoring;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
endmodule

// File: rtl/odc_div.sv
module odc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [odc_pkg::NUM_W-1:0]     num,
  input  logic [odc_pkg::CANG_W-1:0]    den,
  output logic                          done,
  output logic [odc_pkg::NUM_W-1:0]     quo
);
  localparam int CNT_W = $clog2(odc_pkg::NUM_W);

  logic                          busy_r, done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [odc_pkg::NUM_W-1:0]     quo_r;
  logic [odc_pkg::CANG_W-1:0]    den_r, rem_r;
  logic [odc_pkg::CANG_W:0]      trial;
  logic                          fits;

  always_comb begin
    trial = {rem_r, quo_r[odc_pkg::NUM_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(odc_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? odc_pkg::CANG_W'(trial - {1'b0, den_r})
                    : trial[odc_pkg::CANG_W-1:0];
      quo_r <= {quo_r[odc_pkg::NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// File: rtl/obstacle_dispersion_drive_controller_unit.sv
// Random-walk drive controller with obstacle avoidance. Proximity readings of one control
// tick come in one word each; a word above the threshold is turned into a vector by a shared
// CORDIC unit and added to a saturating 24-bit sum. A word marked last then yields one
// result word with the wheel speeds. The block takes one word at a time and finishes the
// CORDIC rotation of a reading above the threshold before it takes the next. The last word
// adds the length test and, where needed, the CORDIC heading and the bit-serial soft-turn
// divider. A new word is taken while the previous result still waits on the output.
module obstacle_dispersion_drive_controller_unit #(
  parameter int SPIN_RANGE   = 50,
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  odc_in_if.sink   in_port,
  odc_out_if.source out_port,
  odc_cfg_if.sink  cfg_port
);
  localparam int TAB_N = 1 << odc_pkg::RND_W;

  odc_pkg::state_t state_r, state_nxt;

  logic [odc_pkg::VALUE_W-1:0]  thr_r;
  logic [15:0]                  still_r;
  logic [7:0]                   wlim_r;
  logic [odc_pkg::CSPD_W-1:0]   wspd_r, sspd_r, mspd_r;
  logic [odc_pkg::CANG_W-1:0]   noturn_r, soft_r;

  logic [odc_pkg::VALUE_W-1:0]      value_r;
  logic signed [odc_pkg::ANGLE_W-1:0] ang_r;
  logic                             last_r;
  logic [odc_pkg::RND_W-1:0]        rnd_r;

  logic signed [odc_pkg::SUM_W-1:0]  sx_r, sy_r;
  logic [7:0]                        wcount_r;
  logic [odc_pkg::RND_W-1:0]         spin_r;
  logic signed [odc_pkg::SPEED_W-1:0] last_l_r, last_rt_r, res_l_r, res_r_r;
  odc_pkg::motion_t                  last_m_r, res_m_r;

  logic [47:0]  sqx_r, sqy_r;
  logic [31:0]  lim_r;
  logic signed [15:0] a_r;
  logic [odc_pkg::NUM_W-1:0] num_r;

  logic                              out_valid_r;
  logic signed [odc_pkg::SPEED_W-1:0] out_l_r, out_rt_r;
  odc_pkg::motion_t                  out_m_r;
  logic [7:0]                        out_t_r;

  odc_pkg::cordic_cmd_t              ccmd;
  logic signed [odc_pkg::CX_W-1:0]   cx0, cy0, cx, cy;
  logic signed [odc_pkg::CZ_W-1:0]   cz0, cz;
  logic                              cdone;
  logic                              dstart, ddone;
  logic [odc_pkg::NUM_W-1:0]         dquo;

  logic [odc_pkg::RND_W-1:0] spin_tab [TAB_N];
  genvar g;
  generate
    for (g = 0; g < TAB_N; g++) begin : g_tab
      assign spin_tab[g] = odc_pkg::RND_W'(g % SPIN_RANGE);
    end
  endgenerate

  logic in_acc, out_free;
  assign in_acc   = in_port.valid && in_port.ready;
  assign out_free = !out_valid_r || out_port.ready;
  assign in_port.ready  = (state_r == odc_pkg::S_IDLE);
  assign cfg_port.ready = 1'b1;

  // rotation and heading start vectors
  logic signed [odc_pkg::CX_W-1:0] rx;
  logic signed [odc_pkg::CZ_W-1:0] rz;
  logic signed [24:0]              hx, hy;
  logic signed [odc_pkg::CX_W-1:0] hxw, hyw;
  always_comb begin
    rx  = $signed({12'd0, 36'(value_r) * 36'(odc_pkg::INV_GAIN_Q24)});
    rz  = $signed({{5{ang_r[odc_pkg::ANGLE_W-1]}}, ang_r, 12'd0});
    hx  = -$signed({sx_r[odc_pkg::SUM_W-1], sx_r});
    hy  = -$signed({sy_r[odc_pkg::SUM_W-1], sy_r});
    hxw = $signed({{3{hx[24]}}, hx, 20'd0});
    hyw = $signed({{3{hy[24]}}, hy, 20'd0});
  end

  always_comb begin
    ccmd = '0;
    cx0  = rx;
    cy0  = '0;
    cz0  = rz;
    dstart = 1'b0;
    case (state_r)
      odc_pkg::S_ROT_GO: begin
        ccmd.start = 1'b1;
        if (rz > odc_pkg::HALF_PI_Q24) begin
          cz0 = rz - odc_pkg::PI_Q24;
          cx0 = -rx;
        end else if (rz < -odc_pkg::HALF_PI_Q24) begin
          cz0 = rz + odc_pkg::PI_Q24;
          cx0 = -rx;
        end
      end
      odc_pkg::S_HEAD_GO: begin
        ccmd.start     = 1'b1;
        ccmd.vectoring = 1'b1;
        cx0 = hxw;
        cy0 = hyw;
        cz0 = '0;
        if (hx < 0) begin
          cx0 = -hxw;
          cy0 = -hyw;
          cz0 = (hy > 0) ? odc_pkg::PI_Q24 : -odc_pkg::PI_Q24;
        end
      end
      odc_pkg::S_DIV_GO: dstart = 1'b1;
      default: ;
    endcase
  end

  odc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(ccmd), .x0(cx0), .y0(cy0), .z0(cz0),
    .done(cdone), .x(cx), .y(cy), .z(cz)
  );

  odc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(num_r), .den(soft_r),
    .done(ddone), .quo(dquo)
  );

  // accumulate step
  logic signed [odc_pkg::CX_W-1:0] rxr, ryr;
  logic signed [25:0]              nsx, nsy;
  logic signed [odc_pkg::SUM_W-1:0] satx, saty;
  always_comb begin
    rxr = (cx + 48'sd524288) >>> 20;
    ryr = (cy + 48'sd524288) >>> 20;
    nsx = $signed({{2{sx_r[23]}}, sx_r}) + $signed(rxr[25:0]);
    nsy = $signed({{2{sy_r[23]}}, sy_r}) + $signed(ryr[25:0]);
    satx = (nsx > 26'sd8388607) ? 24'sh7FFFFF :
           (nsx < -26'sd8388608) ? 24'sh800000 : nsx[23:0];
    saty = (nsy > 26'sd8388607) ? 24'sh7FFFFF :
           (nsy < -26'sd8388608) ? 24'sh800000 : nsy[23:0];
  end

  // decision terms
  logic        still, zero_sum;
  logic [15:0] mag;
  logic signed [odc_pkg::CZ_W-1:0] zr;
  logic [7:0]  winc;
  logic signed [odc_pkg::SPEED_W-1:0] maxs;
  always_comb begin
    still    = ({1'b0, sqx_r} + {1'b0, sqy_r}) < {17'd0, lim_r};
    zero_sum = (sx_r == 0) && (sy_r == 0);
    mag      = a_r[15] ? 16'(-a_r) : 16'(a_r);
    zr       = (cz + 32'sd2048) >>> 12;
    winc     = wcount_r + 8'd1;
    maxs     = $signed({1'b0, mspd_r});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      odc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_port.reading_value > thr_r) state_nxt = odc_pkg::S_ROT_GO;
          else if (in_port.last_reading)     state_nxt = odc_pkg::S_LEN_X;
        end
      end
      odc_pkg::S_ROT_GO:   state_nxt = odc_pkg::S_ROT_WAIT;
      odc_pkg::S_ROT_WAIT: if (cdone) state_nxt = odc_pkg::S_ACC;
      odc_pkg::S_ACC:      state_nxt = last_r ? odc_pkg::S_LEN_X : odc_pkg::S_IDLE;
      odc_pkg::S_LEN_X:    state_nxt = odc_pkg::S_LEN_Y;
      odc_pkg::S_LEN_Y:    state_nxt = odc_pkg::S_LEN_L;
      odc_pkg::S_LEN_L:    state_nxt = odc_pkg::S_CMP;
      odc_pkg::S_CMP: begin
        if (still)         state_nxt = odc_pkg::S_DONE;
        else if (zero_sum) state_nxt = odc_pkg::S_SEL;
        else               state_nxt = odc_pkg::S_HEAD_GO;
      end
      odc_pkg::S_HEAD_GO:   state_nxt = odc_pkg::S_HEAD_WAIT;
      odc_pkg::S_HEAD_WAIT: if (cdone) state_nxt = odc_pkg::S_STEER;
      odc_pkg::S_STEER:     state_nxt = odc_pkg::S_SEL;
      odc_pkg::S_SEL: begin
        if (mag <= {2'd0, noturn_r})   state_nxt = odc_pkg::S_DONE;
        else if (mag <= {2'd0, soft_r}) state_nxt = odc_pkg::S_DIV_MUL;
        else                           state_nxt = odc_pkg::S_DONE;
      end
      odc_pkg::S_DIV_MUL:  state_nxt = odc_pkg::S_DIV_GO;
      odc_pkg::S_DIV_GO:   state_nxt = odc_pkg::S_DIV_WAIT;
      odc_pkg::S_DIV_WAIT: if (ddone) state_nxt = odc_pkg::S_DONE;
      odc_pkg::S_DONE:     if (out_free) state_nxt = odc_pkg::S_IDLE;
      default:             state_nxt = odc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= odc_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 12'd300;
      still_r  <= 16'd6;
      wlim_r   <= 8'd100;
      wspd_r   <= 15'd768;
      sspd_r   <= 15'd1536;
      mspd_r   <= 15'd2560;
      noturn_r <= 14'd819;
      soft_r   <= 14'd2458;
    end else if (cfg_port.valid) begin
      case (odc_pkg::cfg_idx_t'(cfg_port.index))
        odc_pkg::CFG_THRESHOLD: thr_r    <= cfg_port.data[11:0];
        odc_pkg::CFG_STILL_LEN: still_r  <= cfg_port.data;
        odc_pkg::CFG_WALK_LIM:  wlim_r   <= cfg_port.data[7:0];
        odc_pkg::CFG_WALK_SPD:  wspd_r   <= cfg_port.data[14:0];
        odc_pkg::CFG_SPIN_SPD:  sspd_r   <= cfg_port.data[14:0];
        odc_pkg::CFG_MAX_SPD:   mspd_r   <= cfg_port.data[14:0];
        odc_pkg::CFG_NO_TURN:   noturn_r <= cfg_port.data[13:0];
        odc_pkg::CFG_SOFT_TURN: soft_r   <= cfg_port.data[13:0];
        default: ;
      endcase
    end
  end

  // item payload and datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_port.reading_value;
      ang_r   <= in_port.reading_angle;
      last_r  <= in_port.last_reading;
      rnd_r   <= in_port.turn_random;
    end
    case (state_r)
      odc_pkg::S_LEN_X: sqx_r <= 48'(sx_r) * 48'(sx_r);
      odc_pkg::S_LEN_Y: sqy_r <= 48'(sy_r) * 48'(sy_r);
      odc_pkg::S_LEN_L: lim_r <= still_r * still_r;
      odc_pkg::S_CMP:   a_r   <= '0;
      odc_pkg::S_STEER: a_r   <= zr[15:0];
      odc_pkg::S_DIV_MUL: num_r <= mspd_r * (soft_r - mag[13:0]);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r        <= '0;
      sy_r        <= '0;
      wcount_r    <= '0;
      spin_r      <= '0;
      last_l_r    <= '0;
      last_rt_r   <= '0;
      last_m_r    <= odc_pkg::MOT_WALK;
      res_l_r     <= '0;
      res_r_r     <= '0;
      res_m_r     <= odc_pkg::MOT_WALK;
      out_valid_r <= 1'b0;
      out_l_r     <= '0;
      out_rt_r    <= '0;
      out_m_r     <= odc_pkg::MOT_WALK;
      out_t_r     <= '0;
    end else begin
      if (state_r == odc_pkg::S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_port.ready)                    out_valid_r <= 1'b0;
      case (state_r)
        odc_pkg::S_ACC: begin
          sx_r <= satx;
          sy_r <= saty;
        end
        odc_pkg::S_CMP: begin
          if (still) begin
            if (wcount_r < wlim_r) begin
              res_l_r  <= $signed({1'b0, wspd_r});
              res_r_r  <= $signed({1'b0, wspd_r});
              res_m_r  <= odc_pkg::MOT_WALK;
              wcount_r <= winc;
            end else if (wcount_r == wlim_r) begin
              spin_r   <= spin_tab[rnd_r];
              res_l_r  <= last_l_r;
              res_r_r  <= last_rt_r;
              res_m_r  <= last_m_r;
              wcount_r <= winc;
            end else begin
              res_l_r  <= '0;
              res_r_r  <= $signed({1'b0, sspd_r});
              res_m_r  <= odc_pkg::MOT_SPIN;
              wcount_r <= ({1'b0, winc} > ({1'b0, wlim_r} + 9'(spin_r))) ? 8'd0 : winc;
            end
          end else begin
            wcount_r <= '0;
            res_m_r  <= odc_pkg::MOT_AVOID;
          end
        end
        odc_pkg::S_SEL: begin
          if (mag <= {2'd0, noturn_r}) begin
            res_l_r <= maxs;
            res_r_r <= maxs;
          end else if (mag > {2'd0, soft_r}) begin
            res_l_r <= (a_r > 0) ? -maxs : maxs;
            res_r_r <= (a_r > 0) ? maxs : -maxs;
          end
        end
        odc_pkg::S_DIV_WAIT: begin
          if (ddone) begin
            res_l_r <= (a_r > 0) ? $signed({1'b0, dquo[14:0]}) : maxs;
            res_r_r <= (a_r > 0) ? maxs : $signed({1'b0, dquo[14:0]});
          end
        end
        odc_pkg::S_DONE: begin
          if (out_free) begin
            out_l_r     <= res_l_r;
            out_rt_r    <= res_r_r;
            out_m_r     <= res_m_r;
            out_t_r     <= wcount_r;
            last_l_r    <= res_l_r;
            last_rt_r   <= res_r_r;
            last_m_r    <= res_m_r;
            sx_r        <= '0;
            sy_r        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_port.valid        = out_valid_r;
  assign out_port.left_speed   = out_l_r;
  assign out_port.right_speed  = out_rt_r;
  assign out_port.motion_state = out_m_r;
  assign out_port.tick_count   = out_t_r;
endmodule

// File: tb/tb_obstacle_dispersion_drive_controller_unit.sv
`timescale 1ns / 1ps

module tb_obstacle_dispersion_drive_controller_unit;

  localparam int STEPS = 16;
  localparam int SPIN_MOD = 50;
  localparam longint HALF_PI = 64'sd26353589;
  localparam longint FULL_PI = 64'sd52707179;
  localparam longint INV_GAIN = 64'sd10188014;
  localparam longint SUM_HI = 64'sd8388607;
  localparam longint SUM_LO = -64'sd8388608;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic [odc_pkg::VALUE_W-1:0]        value;
    logic signed [odc_pkg::ANGLE_W-1:0] angle;
    logic                               last;
    logic [odc_pkg::RND_W-1:0]          rnd;
  } reading_t;

  typedef struct {
    logic signed [odc_pkg::SPEED_W-1:0] left;
    logic signed [odc_pkg::SPEED_W-1:0] right;
    logic [1:0]                         motion;
    logic [odc_pkg::TIMER_W-1:0]        timer;
  } drive_cmd_t;

  const longint atan_tab[STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
  };

  logic clk;
  logic rst_n;

  odc_in_if  in_bus ();
  odc_out_if out_bus ();
  odc_cfg_if cfg_bus ();

  obstacle_dispersion_drive_controller_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_bus.sink),
    .out_port (out_bus.source),
    .cfg_port (cfg_bus.sink)
  );

  reading_t   pending_readings[$];
  drive_cmd_t expected_cmds[$];
  int errors = 0;
  int acc_cnt = 0;
  int issued = 0;
  int out_cnt = 0;

  // model copy of registers and state
  int thr_r, still_r, wlim_r, wspd_r, sspd_r, mspd_r, nturn_r, sturn_r;
  longint sum_x, sum_y;
  int walk_cnt, spin_len, prev_motion;
  int prev_left, prev_right;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic rotate_reading(input int value, input int ang, output longint ox,
                                output longint oy);
    longint x, y, z, t;
    x = value * INV_GAIN;
    y = 0;
    z = longint'(ang) * 4096;
    if (z > HALF_PI) begin
      z = z - FULL_PI;
      x = -x;
    end else if (z < -HALF_PI) begin
      z = z + FULL_PI;
      x = -x;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - atan_tab[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + atan_tab[i];
      end
    end
    ox = (x + (64'sd1 <<< 19)) >>> 20;
    oy = (y + (64'sd1 <<< 19)) >>> 20;
  endtask

  function automatic longint heading_of(input longint hx, input longint hy);
    longint x, y, z, t;
    if (hx == 0 && hy == 0) return 0;
    x = hx * 1048576;
    y = hy * 1048576;
    z = 0;
    if (x < 0) begin
      z = (y > 0) ? FULL_PI : -FULL_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + atan_tab[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - atan_tab[i];
      end
    end
    return (z + 2048) >>> 12;
  endfunction

  function automatic longint sat_sum(input longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  task automatic predict_drive(input reading_t r);
    longint dx, dy, len2, lim2, a, mag;
    int left, right, motion, inner;
    drive_cmd_t c;
    if (int'(r.value) > thr_r) begin
      rotate_reading(int'(r.value), int'(r.angle), dx, dy);
      sum_x = sat_sum(sum_x + dx);
      sum_y = sat_sum(sum_y + dy);
    end
    if (!r.last) return;
    len2 = sum_x * sum_x + sum_y * sum_y;
    lim2 = longint'(still_r) * longint'(still_r);
    if (len2 < lim2) begin
      if (walk_cnt < wlim_r) begin
        left = wspd_r; right = wspd_r; motion = odc_pkg::MOT_WALK;
        walk_cnt = (walk_cnt + 1) & 8'hFF;
      end else if (walk_cnt == wlim_r) begin
        spin_len = int'(r.rnd) % SPIN_MOD;
        left = prev_left; right = prev_right; motion = prev_motion;
        walk_cnt = (walk_cnt + 1) & 8'hFF;
      end else begin
        left = 0; right = sspd_r; motion = odc_pkg::MOT_SPIN;
        walk_cnt = (walk_cnt + 1) & 8'hFF;
        if (walk_cnt > wlim_r + spin_len) walk_cnt = 0;
      end
    end else begin
      a = heading_of(-sum_x, -sum_y);
      mag = (a < 0) ? -a : a;
      if (mag <= nturn_r) inner = mspd_r;
      else if (mag <= sturn_r && sturn_r != 0)
        inner = int'((longint'(mspd_r) * (sturn_r - mag)) / sturn_r);
      else inner = -mspd_r;
      if (a > 0) begin
        left = inner; right = mspd_r;
      end else begin
        left = mspd_r; right = inner;
      end
      motion = odc_pkg::MOT_AVOID;
      walk_cnt = 0;
    end
    prev_left = left; prev_right = right; prev_motion = motion;
    sum_x = 0; sum_y = 0;
    c.left = left[15:0];
    c.right = right[15:0];
    c.motion = motion[1:0];
    c.timer = walk_cnt[7:0];
    expected_cmds.push_back(c);
  endtask

  // input acceptance and result checking
  always @(posedge clk) begin
    drive_cmd_t e;
    reading_t r;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      r.value = in_bus.reading_value;
      r.angle = in_bus.reading_angle;
      r.last = in_bus.last_reading;
      r.rnd = in_bus.turn_random;
      predict_drive(r);
      acc_cnt <= acc_cnt + 1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      out_cnt <= out_cnt + 1;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected word left=%0d right=%0d motion=%0d count=%0d", $time,
                 out_bus.left_speed, out_bus.right_speed, out_bus.motion_state,
                 out_bus.tick_count);
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        if (out_bus.left_speed !== e.left) begin
          $display("%0t: left_speed expected %0d actual %0d", $time, e.left,
                   out_bus.left_speed);
          errors++;
        end
        if (out_bus.right_speed !== e.right) begin
          $display("%0t: right_speed expected %0d actual %0d", $time, e.right,
                   out_bus.right_speed);
          errors++;
        end
        if (out_bus.motion_state !== e.motion) begin
          $display("%0t: motion_state expected %0d actual %0d", $time, e.motion,
                   out_bus.motion_state);
          errors++;
        end
        if (out_bus.tick_count !== e.timer) begin
          $display("%0t: tick_count expected %0d actual %0d", $time, e.timer,
                   out_bus.tick_count);
          errors++;
        end
      end
    end
  end

  // driver: bursts with random gaps
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk) begin
    reading_t r;
    if (rst_n) begin
      if (in_bus.valid && acc_cnt != issued) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_readings.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else begin
        r = pending_readings.pop_front();
        in_bus.reading_value <= r.value;
        in_bus.reading_angle <= r.angle;
        in_bus.last_reading <= r.last;
        in_bus.turn_random <= r.rnd;
        in_bus.valid <= 1'b1;
        issued++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 4);
            2: gap_left = $urandom_range(5, 40);
            default: gap_left = $urandom_range(1, 12);
          endcase
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold
  int hold_cnt = 0;
  bit held = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 160);
      end else rx_mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_bus.ready <= 1'b0;
      end else if (!held && out_cnt == 150) begin
        held = 1;
        hold_cnt = 500;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic add_reading(input int value, input int ang, input bit last, input int rnd);
    reading_t r;
    r.value = value[odc_pkg::VALUE_W-1:0];
    r.angle = ang[odc_pkg::ANGLE_W-1:0];
    r.last = last;
    r.rnd = rnd[odc_pkg::RND_W-1:0];
    pending_readings.push_back(r);
  endtask

  task automatic add_random_tick(input int quiet_pct);
    int n, val, ang;
    bit quiet;
    n = $urandom_range(1, 8);
    quiet = ($urandom_range(0, 99) < quiet_pct);
    for (int i = 0; i < n; i++) begin
      if (quiet) val = $urandom_range(0, thr_r);
      else if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 4095);
      else val = $urandom_range((thr_r < 4095) ? thr_r + 1 : 0, 4095);
      if ($urandom_range(0, 9) == 0) ang = $urandom_range(0, 32767) - 16384;
      else ang = $urandom_range(0, 25736) - 12868;
      add_reading(val, ang, i == n - 1, $urandom_range(0, 63));
    end
  endtask

  task automatic wait_idle();
    while (pending_readings.size() != 0 || acc_cnt != issued || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input odc_pkg::cfg_idx_t idx, input int val);
    @(negedge clk);
    cfg_bus.index <= idx;
    cfg_bus.data <= val[odc_pkg::CFG_DATA_W-1:0];
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      odc_pkg::CFG_THRESHOLD: thr_r = val & 12'hFFF;
      odc_pkg::CFG_STILL_LEN: still_r = val & 16'hFFFF;
      odc_pkg::CFG_WALK_LIM:  wlim_r = val & 8'hFF;
      odc_pkg::CFG_WALK_SPD:  wspd_r = val & 15'h7FFF;
      odc_pkg::CFG_SPIN_SPD:  sspd_r = val & 15'h7FFF;
      odc_pkg::CFG_MAX_SPD:   mspd_r = val & 15'h7FFF;
      odc_pkg::CFG_NO_TURN:   nturn_r = val & 14'h3FFF;
      odc_pkg::CFG_SOFT_TURN: sturn_r = val & 14'h3FFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_config(input int thr, input int still, input int wlim, input int wspd,
                            input int sspd, input int mspd, input int nt, input int st);
    write_reg(odc_pkg::CFG_THRESHOLD, thr);
    write_reg(odc_pkg::CFG_STILL_LEN, still);
    write_reg(odc_pkg::CFG_WALK_LIM, wlim);
    write_reg(odc_pkg::CFG_WALK_SPD, wspd);
    write_reg(odc_pkg::CFG_SPIN_SPD, sspd);
    write_reg(odc_pkg::CFG_MAX_SPD, mspd);
    write_reg(odc_pkg::CFG_NO_TURN, nt);
    write_reg(odc_pkg::CFG_SOFT_TURN, st);
  endtask

  task automatic run_random(input int items, input int quiet_pct);
    int start;
    start = issued + pending_readings.size();
    while (issued + pending_readings.size() - start < items) add_random_tick(quiet_pct);
  endtask

  initial begin
    #3000000;
    $display("tb_obstacle_dispersion_drive_controller_unit failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.reading_value = '0;
    in_bus.reading_angle = '0;
    in_bus.last_reading = 1'b0;
    in_bus.turn_random = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = odc_pkg::CFG_THRESHOLD;
    cfg_bus.data = '0;
    thr_r = 300; still_r = 6; wlim_r = 100; wspd_r = 768; sspd_r = 1536;
    mspd_r = 2560; nturn_r = 819; sturn_r = 2458;
    sum_x = 0; sum_y = 0; walk_cnt = 0; spin_len = 0; prev_motion = odc_pkg::MOT_WALK;
    prev_left = 0; prev_right = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed ticks at reset settings
    add_reading(0, 0, 1, 0);
    add_reading(4095, 12868, 1, 63);
    add_reading(4095, -12868, 1, 0);
    add_reading(4095, 0, 1, 5);
    add_reading(4095, 16383, 1, 49);
    add_reading(4095, -16384, 1, 50);
    add_reading(300, 3000, 1, 63);
    add_reading(301, 6434, 0, 1);
    add_reading(2000, 6434, 1, 2);
    add_reading(3000, 1000, 0, 3);
    add_reading(3000, 1000 - 12868, 1, 4);
    add_reading(1000, 0, 0, 0);
    add_reading(1000, 12868, 1, 0);
    add_reading(4095, -3000, 0, 7);
    add_reading(600, 2000, 0, 7);
    add_reading(0, 0, 1, 7);
    add_reading(4095, 8192, 1, 21);
    add_reading(4095, -8192, 1, 42);
    wait_idle();
    run_random(200, 50);
    wait_idle();

    // short walk limit so spins are reached often
    set_config(300, 6, 3, 768, 1536, 2560, 819, 2458);
    run_random(280, 85);
    wait_idle();

    // low extremes: zero threshold, zero still length, saturating sum
    set_config(0, 0, 1, 32767, 32767, 32767, 0, 12868);
    add_reading(0, 0, 1, 0);
    for (int i = 0; i < 140; i++) add_reading(4095, 0, i == 139, 0);
    for (int i = 0; i < 140; i++) add_reading(4095, 6434, i == 139, 0);
    run_random(200, 30);
    wait_idle();

    // high extremes: always still, long walk limit of 200
    set_config(4095, 65535, 200, 0, 0, 0, 12868, 1);
    run_random(260, 50);
    wait_idle();

    set_config(100, 40, 1, 1000, 2000, 20000, 12868, 12868);
    run_random(200, 70);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      set_config($urandom_range(0, 4095), $urandom_range(0, 3000), $urandom_range(1, 8),
                 $urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 32767),
                 $urandom_range(0, 12868), $urandom_range(1, 12868));
      run_random(110, 75);
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_obstacle_dispersion_drive_controller_unit passed");
    end else begin
      $display("tb_obstacle_dispersion_drive_controller_unit failed");
    end
    $finish;
  end

endmodule
